// File: hw/rtl/bpfa_pkg.sv
// bpfa_pkg: shared types and constants of the bitmap page frame allocator
// item structs, operation codes, status codes and configuration register indexes
// no dependencies
package bpfa_pkg;

	localparam int unsigned ADDR_W     = 48;
	localparam int unsigned IDX_W      = 12;
	localparam int unsigned REG_W      = 13;
	localparam int unsigned PAGE_SHIFT = 12;
	localparam int unsigned CFG_IDX_W  = 2;

	// operation codes
	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_INIT  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DATA_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESERVED    = 2'd2;

	typedef struct packed {
		logic [1:0]        op;
		logic [ADDR_W-1:0] free_addr;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] frame_addr;
		logic [IDX_W-1:0]  frame_num;
		logic [1:0]        status;
	} out_item_t;

endpackage

// File: hw/rtl/bitmap_page_frame_allocator.sv
// bitmap_page_frame_allocator: one used/free bit per 4 KiB page frame
// allocate, free and initialize requests over a word-wide bitmap memory
// depends on bpfa_pkg
//
// channel   dir  handshake             payload
// in        in   in_valid / in_ready   bpfa_pkg::in_item_t  (op, free_addr)
// out       out  out_valid / out_ready bpfa_pkg::out_item_t (frame_addr, frame_num, status)
// cfg       in   cfg_wr_en             cfg_index, cfg_wdata (no wait, no read-back)
//
// allocate: scans the bitmap word by word, at most MAP_WORDS words; the single
//   read port of the bitmap memory sets the pace, one word per cycle
// free: subtract, range check and word split, read, write back (skipped when out of range)
// initialize: rewrites all MAP_WORDS bitmap words, one bitmap word written per cycle
// after reset a clearing pass writes all MAP_WORDS words; in_ready stays low meanwhile
// one item is worked on at a time; a finished item waits in the output register,
//   so the next item is taken while out_ready is low

module bitmap_page_frame_allocator #(
	parameter int unsigned MAX_FRAMES    = 4096,
	parameter int unsigned MAP_WORD_BITS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// request channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  bpfa_pkg::in_item_t                   in_item,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output bpfa_pkg::out_item_t                  out_item,
	// configuration write port
	input  logic                                 cfg_wr_en,
	input  logic [bpfa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bpfa_pkg::ADDR_W-1:0]          cfg_wdata
);

	// bitmap geometry
	localparam int unsigned MAP_WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int unsigned WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int unsigned BIT_W     = $clog2(MAP_WORD_BITS);
	// frame numbers up to one word past the end of the map
	localparam int unsigned BASE_W    = $clog2(MAX_FRAMES + MAP_WORD_BITS) + 1;
	// largest count that a 13 bit register can ask for, capped by the map size
	localparam int unsigned CAP       = (MAX_FRAMES < 8191) ? MAX_FRAMES : 8191;
	localparam logic [bpfa_pkg::REG_W-1:0] CAP_R = bpfa_pkg::REG_W'(CAP);
	// frame / MAP_WORD_BITS as a reciprocal multiply, exact for frames below 2^13
	localparam int unsigned RSH       = 24;
	localparam int unsigned RECIP     = ((1 << RSH) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int unsigned PROD_W    = bpfa_pkg::REG_W + 32;
	localparam int unsigned FRN_W     = bpfa_pkg::ADDR_W - bpfa_pkg::PAGE_SHIFT;

	typedef enum logic [3:0] {
		S_CLEAR,   // writes one bitmap word per cycle (reset pass and initialize)
		S_IDLE,
		S_SCAN,    // reads one word per cycle, checks the word read in the cycle before
		S_HIT,     // writes back the word with the found bit set
		S_FR_SUB,
		S_FR_CHK,
		S_FR_RD,
		S_FR_WR,
		S_DONE     // hands the result to the output register
	} state_t;

	state_t state_q;

	// configuration registers
	logic [bpfa_pkg::ADDR_W-1:0] data_base_q;
	logic [bpfa_pkg::REG_W-1:0]  frame_count_q;
	logic [bpfa_pkg::REG_W-1:0]  reserved_q;

	// bitmap memory
	logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
	logic [MAP_WORD_BITS-1:0] rd_data_q;
	logic                     rd_en;
	logic [WADDR_W-1:0]       rd_addr;
	logic                     wr_en;
	logic [WADDR_W-1:0]       wr_addr;
	logic [MAP_WORD_BITS-1:0] wr_data;

	// sweep / scan pointer
	logic [WADDR_W-1:0] ptr_q;
	logic [BASE_W-1:0]  ptr_base_q;
	logic               chk_vld_q;
	logic [WADDR_W-1:0] chk_word_q;
	logic [BASE_W-1:0]  chk_base_q;
	logic [bpfa_pkg::REG_W-1:0] resv_lim_q;
	logic               init_res_q;

	// allocate hit
	logic [WADDR_W-1:0]       hit_word_q;
	logic [BASE_W-1:0]        hit_frame_q;
	logic [MAP_WORD_BITS-1:0] hit_data_q;

	// free path
	logic [bpfa_pkg::ADDR_W-1:0] fr_addr_q;
	logic [bpfa_pkg::ADDR_W-1:0] fr_diff_q;
	logic                        fr_below_q;
	logic [bpfa_pkg::REG_W-1:0]  fr_frame_q;
	logic [WADDR_W-1:0]          fr_word_q;
	logic [BIT_W-1:0]            fr_bit_q;

	// result and output register
	bpfa_pkg::out_item_t res_q;
	bpfa_pkg::out_item_t out_q;
	logic                out_valid_q;

	// combinational helpers
	logic [bpfa_pkg::REG_W-1:0] eff_count;
	logic [BASE_W-1:0]          eff_count_b;
	logic                       issue_ok;
	logic [BASE_W-1:0]          rem;
	logic [MAP_WORD_BITS-1:0]   free_vec;
	logic                       hit_any;
	logic [BIT_W-1:0]           hit_bit;
	logic [MAP_WORD_BITS-1:0]   init_mask;
	logic [bpfa_pkg::ADDR_W:0]  fr_sub;
	logic [PROD_W-1:0]          fr_prod;
	logic [bpfa_pkg::REG_W-1:0] fr_frame_n;
	logic [BASE_W-1:0]          fr_bit_full;
	logic                       last_word;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// effective frame count: never more than the map holds
	assign eff_count   = (frame_count_q > CAP_R) ? CAP_R : frame_count_q;
	assign eff_count_b = BASE_W'(eff_count);
	// the word at the pointer holds at least one frame below the count
	assign issue_ok    = (ptr_base_q < eff_count_b);
	assign last_word   = (ptr_q == WADDR_W'(MAP_WORDS - 1));

	// lowest free bit of the checked word among frames below the count
	always_comb begin
		rem      = eff_count_b - chk_base_q;
		free_vec = '0;
		hit_bit  = '0;
		for (int b = 0; b < MAP_WORD_BITS; b++) begin
			free_vec[b] = ~rd_data_q[b] && (BASE_W'(b) < rem);
		end
		for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
			if (free_vec[b]) begin
				hit_bit = BIT_W'(b);
			end
		end
		hit_any = |free_vec;
	end

	// word pattern written by the sweep: leading reserved frames set
	always_comb begin
		for (int b = 0; b < MAP_WORD_BITS; b++) begin
			init_mask[b] = (ptr_base_q + BASE_W'(b)) < BASE_W'(resv_lim_q);
		end
	end

	// free path arithmetic
	assign fr_sub      = {1'b0, fr_addr_q} - {1'b0, data_base_q};
	assign fr_frame_n  = fr_diff_q[bpfa_pkg::PAGE_SHIFT +: bpfa_pkg::REG_W];
	assign fr_prod     = PROD_W'(fr_frame_n) * PROD_W'(RECIP);
	assign fr_bit_full = BASE_W'(fr_frame_q)
		- BASE_W'(BASE_W'(fr_word_q) * BASE_W'(MAP_WORD_BITS));

	// memory port selection
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ptr_q;
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_data = init_mask;
		unique case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_SCAN: begin
				rd_en = issue_ok;
			end
			S_HIT: begin
				wr_en   = 1'b1;
				wr_addr = hit_word_q;
				wr_data = hit_data_q;
			end
			S_FR_RD: begin
				rd_en   = 1'b1;
				rd_addr = fr_word_q;
			end
			S_FR_WR: begin
				wr_en   = 1'b1;
				wr_addr = fr_word_q;
				wr_data = rd_data_q & ~(MAP_WORD_BITS'(1) << fr_bit_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= map_mem[rd_addr];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_base_q   <= '0;
			frame_count_q <= bpfa_pkg::REG_W'(4096);
			reserved_q    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bpfa_pkg::REG_DATA_BASE:   data_base_q   <= cfg_wdata;
				bpfa_pkg::REG_FRAME_COUNT: frame_count_q <= cfg_wdata[bpfa_pkg::REG_W-1:0];
				bpfa_pkg::REG_RESERVED:    reserved_q    <= cfg_wdata[bpfa_pkg::REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			ptr_q       <= '0;
			ptr_base_q  <= '0;
			chk_vld_q   <= 1'b0;
			resv_lim_q  <= '0;
			init_res_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// the done state reloads the output register itself
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					ptr_q      <= ptr_q + WADDR_W'(1);
					ptr_base_q <= ptr_base_q + BASE_W'(MAP_WORD_BITS);
					if (last_word) begin
						state_q <= init_res_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						ptr_q      <= '0;
						ptr_base_q <= '0;
						chk_vld_q  <= 1'b0;
						fr_addr_q  <= in_item.free_addr;
						res_q      <= '0;
						unique case (in_item.op)
							bpfa_pkg::OP_ALLOC: state_q <= S_SCAN;
							bpfa_pkg::OP_FREE:  state_q <= S_FR_SUB;
							bpfa_pkg::OP_INIT: begin
								resv_lim_q <= (reserved_q < eff_count) ? reserved_q
									: eff_count;
								init_res_q <= 1'b1;
								state_q    <= S_CLEAR;
							end
							bpfa_pkg::OP_NOP:   state_q <= S_DONE;
							default:            state_q <= S_DONE;
						endcase
					end
				end
				S_SCAN: begin
					priority if (chk_vld_q && hit_any) begin
						hit_word_q  <= chk_word_q;
						hit_frame_q <= chk_base_q + BASE_W'(hit_bit);
						hit_data_q  <= rd_data_q | (MAP_WORD_BITS'(1) << hit_bit);
						state_q     <= S_HIT;
					end else if (issue_ok) begin
						// read the next word while the current one is checked
						chk_vld_q  <= 1'b1;
						chk_word_q <= ptr_q;
						chk_base_q <= ptr_base_q;
						ptr_q      <= ptr_q + WADDR_W'(1);
						ptr_base_q <= ptr_base_q + BASE_W'(MAP_WORD_BITS);
					end else begin
						res_q.status <= bpfa_pkg::ST_FULL;
						state_q      <= S_DONE;
					end
				end
				S_HIT: begin
					res_q.frame_addr <= data_base_q
						+ (bpfa_pkg::ADDR_W'(hit_frame_q) << bpfa_pkg::PAGE_SHIFT);
					res_q.frame_num  <= hit_frame_q[bpfa_pkg::IDX_W-1:0];
					res_q.status     <= bpfa_pkg::ST_OK;
					state_q          <= S_DONE;
				end
				S_FR_SUB: begin
					fr_diff_q  <= fr_sub[bpfa_pkg::ADDR_W-1:0];
					fr_below_q <= fr_sub[bpfa_pkg::ADDR_W];
					state_q    <= S_FR_CHK;
				end
				S_FR_CHK: begin
					if (fr_below_q || (fr_diff_q[bpfa_pkg::ADDR_W-1:bpfa_pkg::PAGE_SHIFT]
						>= FRN_W'(eff_count))) begin
						res_q.status <= bpfa_pkg::ST_RANGE;
						state_q      <= S_DONE;
					end else begin
						fr_frame_q <= fr_frame_n;
						fr_word_q  <= fr_prod[RSH +: WADDR_W];
						state_q    <= S_FR_RD;
					end
				end
				S_FR_RD: begin
					fr_bit_q <= fr_bit_full[BIT_W-1:0];
					state_q  <= S_FR_WR;
				end
				S_FR_WR: begin
					res_q.frame_num <= fr_frame_q[bpfa_pkg::IDX_W-1:0];
					res_q.status    <= bpfa_pkg::ST_OK;
					state_q         <= S_DONE;
				end
				S_DONE: begin
					// output register free or emptied this cycle
					if (!out_valid_q || out_ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						init_res_q  <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: tb/bitmap_page_frame_allocator_tb.sv
// bitmap_page_frame_allocator_tb: self-checking bench for the bitmap page frame allocator
// drives allocate, free, initialize and no-op items under random idling, predicts every result
// depends on bpfa_pkg and bitmap_page_frame_allocator
module bitmap_page_frame_allocator_tb;

	localparam int unsigned NUM_FRAMES = 4096;
	localparam int unsigned MAP_WORDS  = NUM_FRAMES / 64;
	// worst allocate latency plus some margin
	localparam int unsigned SETTLE_CYCLES = MAP_WORDS + 16;
	localparam int unsigned PHASE_ITEMS   = 255;

	// frame map predictor and queue of predicted results
	class alloc_scoreboard;
		logic [NUM_FRAMES-1:0]           used_frames;
		logic [bpfa_pkg::ADDR_W-1:0]     base;
		logic [bpfa_pkg::REG_W-1:0]      count_reg;
		logic [bpfa_pkg::REG_W-1:0]      reserved_reg;
		bpfa_pkg::out_item_t             expected_q[$];
		int                              errors;
		int                              n_items;
		int                              n_results;
		int                              n_alloc;
		int                              n_full;
		int                              n_range;

		function new();
			used_frames  = '0;
			base         = '0;
			count_reg    = bpfa_pkg::REG_W'(NUM_FRAMES);
			reserved_reg = '0;
			errors       = 0;
			n_items      = 0;
			n_results    = 0;
			n_alloc      = 0;
			n_full       = 0;
			n_range      = 0;
		endfunction

		function void write_reg(logic [bpfa_pkg::CFG_IDX_W-1:0] idx,
			logic [bpfa_pkg::ADDR_W-1:0] val);
			case (idx)
				bpfa_pkg::REG_DATA_BASE:   base = val;
				bpfa_pkg::REG_FRAME_COUNT: count_reg = val[bpfa_pkg::REG_W-1:0];
				bpfa_pkg::REG_RESERVED:    reserved_reg = val[bpfa_pkg::REG_W-1:0];
				default: ;
			endcase
		endfunction

		// counts above the map capacity are clipped
		function int unsigned eff_count();
			return (count_reg < NUM_FRAMES) ? int'(count_reg) : NUM_FRAMES;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_input(bpfa_pkg::in_item_t it);
			bpfa_pkg::out_item_t         r;
			int unsigned                 cnt;
			int unsigned                 lim;
			logic [bpfa_pkg::ADDR_W-1:0] off;
			logic [bpfa_pkg::ADDR_W-1:0] fr;
			bit                          hit;
			r = '0;
			cnt = eff_count();
			n_items++;
			case (it.op)
				bpfa_pkg::OP_ALLOC: begin
					hit = 1'b0;
					for (int f = 0; f < cnt && !hit; f++) begin
						if (!used_frames[f]) begin
							used_frames[f] = 1'b1;
							r.frame_addr   = base
								+ (bpfa_pkg::ADDR_W'(f) << bpfa_pkg::PAGE_SHIFT);
							r.frame_num    = bpfa_pkg::IDX_W'(f);
							hit            = 1'b1;
						end
					end
					if (hit)
						n_alloc++;
					else
						r.status = bpfa_pkg::ST_FULL;
				end
				bpfa_pkg::OP_FREE: begin
					if (it.free_addr < base) begin
						r.status = bpfa_pkg::ST_RANGE;
					end else begin
						off = it.free_addr - base;
						fr  = off >> bpfa_pkg::PAGE_SHIFT;
						if (fr >= cnt) begin
							r.status = bpfa_pkg::ST_RANGE;
						end else begin
							used_frames[fr[bpfa_pkg::IDX_W-1:0]] = 1'b0;
							r.frame_num = fr[bpfa_pkg::IDX_W-1:0];
						end
					end
				end
				bpfa_pkg::OP_INIT: begin
					used_frames = '0;
					lim = (reserved_reg < cnt) ? int'(reserved_reg) : cnt;
					for (int f = 0; f < lim; f++)
						used_frames[f] = 1'b1;
				end
				default: ;
			endcase
			expected_q.push_back(r);
		endfunction

		function void check_result(bpfa_pkg::out_item_t got);
			bpfa_pkg::out_item_t exp;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, got addr %h index %h status %0d",
					$time, got.frame_addr, got.frame_num, got.status);
				return;
			end
			exp = expected_q.pop_front();
			n_results++;
			if (exp.status == bpfa_pkg::ST_FULL)
				n_full++;
			else if (exp.status == bpfa_pkg::ST_RANGE)
				n_range++;
			if (got.frame_addr !== exp.frame_addr) begin
				errors++;
				$display("%0t: frame_addr mismatch, expected %h, got %h",
					$time, exp.frame_addr, got.frame_addr);
			end
			if (got.frame_num !== exp.frame_num) begin
				errors++;
				$display("%0t: frame_num mismatch, expected %h, got %h",
					$time, exp.frame_num, got.frame_num);
			end
			if (got.status !== exp.status) begin
				errors++;
				$display("%0t: status mismatch, expected %0d, got %0d",
					$time, exp.status, got.status);
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	bpfa_pkg::in_item_t             in_item;
	logic                           out_valid;
	logic                           out_ready;
	bpfa_pkg::out_item_t            out_item;
	logic                           cfg_wr_en;
	logic [bpfa_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [bpfa_pkg::ADDR_W-1:0]    cfg_wdata;

	alloc_scoreboard sb;
	int              tx_idle_pct;
	int              rx_idle_pct;
	// rough count of frames handed out since the last initialize, steers free addresses
	int unsigned     alloc_hint;

	bitmap_page_frame_allocator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver side: random back-pressure on the result channel
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
	end

	// every accepted result goes straight to the checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_item);
	end

	function automatic logic [bpfa_pkg::ADDR_W-1:0] rand_addr();
		return bpfa_pkg::ADDR_W'({$urandom(), $urandom()});
	endfunction

	// a free address near the frames in use, sometimes just past the count
	function automatic logic [bpfa_pkg::ADDR_W-1:0] pick_free_addr();
		int unsigned e;
		int unsigned h;
		int unsigned lim;
		int unsigned f;
		e   = sb.eff_count();
		h   = alloc_hint + sb.reserved_reg + 4;
		lim = (e + 1 < h) ? e + 1 : h;
		f   = $urandom_range(lim, 0);
		return sb.base + (bpfa_pkg::ADDR_W'(f) << bpfa_pkg::PAGE_SHIFT)
			+ bpfa_pkg::ADDR_W'($urandom_range(4095, 0));
	endfunction

	// one request item; valid stays high from one item to the next when there is no gap
	task automatic send_req(logic [1:0] op, logic [bpfa_pkg::ADDR_W-1:0] addr);
		bpfa_pkg::in_item_t it;
		int                 gap;
		it.op        = op;
		it.free_addr = addr;
		gap = 0;
		if ($urandom_range(99, 0) < tx_idle_pct)
			gap = ($urandom_range(3, 0) == 0) ? $urandom_range(80, 1) : $urandom_range(4, 1);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_input(it);
		if (op == bpfa_pkg::OP_ALLOC)
			alloc_hint++;
		else if (op == bpfa_pkg::OP_INIT)
			alloc_hint = 0;
	endtask

	// hold off the sender until every predicted result has been seen
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [bpfa_pkg::CFG_IDX_W-1:0] idx,
		logic [bpfa_pkg::ADDR_W-1:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic set_config(logic [bpfa_pkg::ADDR_W-1:0] b, int unsigned cnt,
		int unsigned res);
		cfg_write(bpfa_pkg::REG_DATA_BASE, b);
		cfg_write(bpfa_pkg::REG_FRAME_COUNT, bpfa_pkg::ADDR_W'(cnt));
		cfg_write(bpfa_pkg::REG_RESERVED, bpfa_pkg::ADDR_W'(res));
	endtask

	// one random phase: fresh settings, an initialize, then mostly well-formed traffic
	task automatic run_phase(int ph, int n);
		logic [bpfa_pkg::ADDR_W-1:0] b;
		int unsigned                 cnt;
		int unsigned                 res;
		int unsigned                 new_cnt;
		int unsigned                 sel;
		b = rand_addr();
		case (ph % 6)
			0: begin
				// full-size map, page aligned base, few reserved frames
				b   = {b[bpfa_pkg::ADDR_W-1:bpfa_pkg::PAGE_SHIFT], 12'h000};
				cnt = NUM_FRAMES;
				res = $urandom_range(64, 0);
			end
			1: begin
				// base near the top of the address space so frame addresses wrap
				b   = 48'hFFFF_FFFF_F000 - bpfa_pkg::ADDR_W'($urandom_range(8, 0)) * 4096
					+ bpfa_pkg::ADDR_W'($urandom_range(4095, 0));
				cnt = $urandom_range(130, 1);
				res = $urandom_range(cnt, 0);
			end
			2: begin
				// count above capacity and a nearly full map: long scans
				b   = {b[bpfa_pkg::ADDR_W-1:bpfa_pkg::PAGE_SHIFT], 12'h000};
				cnt = (1 << bpfa_pkg::REG_W) - 1;
				res = $urandom_range(NUM_FRAMES - 1, NUM_FRAMES - 200);
			end
			3: begin
				// unaligned base, reserved at or beyond the count
				cnt = $urandom_range(300, 1);
				res = $urandom_range(cnt + 20, cnt);
			end
			4: begin
				// one word exactly, all reserved
				b   = '0;
				cnt = 64;
				res = 64;
			end
			default: begin
				b   = {b[bpfa_pkg::ADDR_W-1:bpfa_pkg::PAGE_SHIFT], 12'h000};
				cnt = $urandom_range(NUM_FRAMES, 1);
				res = $urandom_range(cnt / 2, 0);
			end
		endcase
		drain();
		set_config(b, cnt, res);
		send_req(bpfa_pkg::OP_INIT, rand_addr());
		for (int i = 0; i < n; i++) begin
			if (i == n / 2) begin
				// change the count without an initialize, stale bits stay in the map
				drain();
				new_cnt = $urandom_range(cnt + 16, (cnt > 16) ? cnt - 16 : 0);
				if (new_cnt > (1 << bpfa_pkg::REG_W) - 1)
					new_cnt = (1 << bpfa_pkg::REG_W) - 1;
				cfg_write(bpfa_pkg::REG_FRAME_COUNT, bpfa_pkg::ADDR_W'(new_cnt));
			end
			sel = $urandom_range(99, 0);
			if (sel < 45)
				send_req(bpfa_pkg::OP_ALLOC, rand_addr());
			else if (sel < 85)
				send_req(bpfa_pkg::OP_FREE, pick_free_addr());
			else if (sel < 89)
				send_req(bpfa_pkg::OP_INIT, rand_addr());
			else if (sel < 93)
				send_req(bpfa_pkg::OP_NOP, rand_addr());
			else if (sel < 97)
				send_req(bpfa_pkg::OP_FREE, rand_addr());
			else
				send_req(bpfa_pkg::OP_FREE, sb.base - 1);
		end
	endtask

	initial begin
		sb          = new();
		tx_idle_pct = 33;
		rx_idle_pct = 58;
		alloc_hint  = 0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		in_item   <= '0;
		out_ready <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= bpfa_pkg::REG_DATA_BASE;
		cfg_wdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset defaults, map starts empty
		send_req(bpfa_pkg::OP_ALLOC, '0);
		send_req(bpfa_pkg::OP_ALLOC, '1);
		send_req(bpfa_pkg::OP_ALLOC, '0);
		// unaligned free truncates to frame one
		send_req(bpfa_pkg::OP_FREE, 48'h0000_0000_1ABC);
		// freeing a frame that is already free
		send_req(bpfa_pkg::OP_FREE, 48'h0000_0000_7000);
		send_req(bpfa_pkg::OP_ALLOC, '0);
		send_req(bpfa_pkg::OP_NOP, '1);
		// far beyond the count
		send_req(bpfa_pkg::OP_FREE, '1);
		send_req(bpfa_pkg::OP_FREE, '0);

		// count and reserved above capacity, base at the very top
		drain();
		set_config(48'hFFFF_FFFF_F000, (1 << bpfa_pkg::REG_W) - 1,
			(1 << bpfa_pkg::REG_W) - 1);
		send_req(bpfa_pkg::OP_INIT, '0);
		send_req(bpfa_pkg::OP_ALLOC, '0);
		// below base
		send_req(bpfa_pkg::OP_FREE, '0);
		// reserved frame freed anyway
		send_req(bpfa_pkg::OP_FREE, '1);
		send_req(bpfa_pkg::OP_ALLOC, '0);
		send_req(bpfa_pkg::OP_ALLOC, '0);

		// zero frames managed
		drain();
		cfg_write(bpfa_pkg::REG_FRAME_COUNT, '0);
		send_req(bpfa_pkg::OP_ALLOC, '0);
		send_req(bpfa_pkg::OP_FREE, 48'hFFFF_FFFF_F000);
		send_req(bpfa_pkg::OP_INIT, '0);

		// single frame, unaligned base
		drain();
		set_config(48'h0000_0000_0123, 1, 0);
		send_req(bpfa_pkg::OP_INIT, '0);
		send_req(bpfa_pkg::OP_ALLOC, '0);
		send_req(bpfa_pkg::OP_ALLOC, '0);
		send_req(bpfa_pkg::OP_FREE, 48'h0000_0000_0122);
		send_req(bpfa_pkg::OP_FREE, 48'h0000_0000_1123);
		send_req(bpfa_pkg::OP_FREE, 48'h0000_0000_1122);
		send_req(bpfa_pkg::OP_ALLOC, '0);

		// random phases under the three idle patterns
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				tx_idle_pct = 58;
				rx_idle_pct = 33;
			end else if (ph == 4) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			run_phase(ph, PHASE_ITEMS);
		end

		in_valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d items and %0d results: %0d allocations, %0d map full,",
			sb.n_items, sb.n_results, sb.n_alloc, sb.n_full);
		$display("%0d bad frees; counts 0 to 8191, reserved past count, wrapping bases",
			sb.n_range);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS bitmap_page_frame_allocator");
		else
			$display("FAIL bitmap_page_frame_allocator");
		$finish;
	end

	// watchdog well above the slowest legal run
	initial begin
		#12_000_000;
		$display("timeout with %0d results outstanding", sb.pending());
		$display("FAIL bitmap_page_frame_allocator");
		$finish;
	end

endmodule
